// ===== rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the point rotate and scale unit: item
// structs, register indexes, fixed-point widths and the arctangent table.
// ----------------------------------------------------------------------------
package prs_pkg;

	// Coordinate width of one item field
	localparam int COORD_BITS = 16;

	// Fractional bits of the CORDIC datapath
	localparam int FRAC_BITS = 16;

	// Configuration port
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROTATION_ANGLE = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_FACTOR   = CFG_INDEX_BITS'(1);

	localparam logic [15:0] ROTATION_ANGLE_RESET = 16'd0;
	localparam logic [15:0] SCALE_FACTOR_RESET   = 16'd256;

	// 1/K in unsigned Q0.30
	localparam int                INV_GAIN_BITS = 30;
	localparam logic [29:0]       INV_GAIN_Q30  = 30'd652032874;
	localparam int                GAIN_BITS     = INV_GAIN_BITS + 16;

	// Arctangent table, units of 2^-32 turn
	localparam int ATAN_ENTRIES = 24;
	localparam int ANGLE_BITS   = 32;

	// Quadrant selected by the rotation angle
	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_in;
		logic signed [COORD_BITS-1:0] y_in;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_out;
		logic signed [COORD_BITS-1:0] y_out;
		logic                         clipped;
	} point_out_t;

	// atan(2^-i) in 2^-32 turn, rounded to nearest
	function automatic logic signed [ANGLE_BITS-1:0] atan_turns(input logic [4:0] idx);
		logic signed [ANGLE_BITS-1:0] a;
		case (idx)
			5'd0:    a = 32'sd536870912;
			5'd1:    a = 32'sd316933406;
			5'd2:    a = 32'sd167458907;
			5'd3:    a = 32'sd85004756;
			5'd4:    a = 32'sd42667331;
			5'd5:    a = 32'sd21354465;
			5'd6:    a = 32'sd10679838;
			5'd7:    a = 32'sd5340245;
			5'd8:    a = 32'sd2670163;
			5'd9:    a = 32'sd1335087;
			5'd10:   a = 32'sd667544;
			5'd11:   a = 32'sd333772;
			5'd12:   a = 32'sd166886;
			5'd13:   a = 32'sd83443;
			5'd14:   a = 32'sd41722;
			5'd15:   a = 32'sd20861;
			5'd16:   a = 32'sd10430;
			5'd17:   a = 32'sd5215;
			5'd18:   a = 32'sd2608;
			5'd19:   a = 32'sd1304;
			5'd20:   a = 32'sd652;
			5'd21:   a = 32'sd326;
			5'd22:   a = 32'sd163;
			5'd23:   a = 32'sd81;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/point_rotate_and_scale_unit.sv =====
// ----------------------------------------------------------------------------
// point_rotate_and_scale_unit
// Rotates a signed point about the origin by a configured binary angle and
// scales it by a configured Q8.8 factor, using a pipelined CORDIC.
// ----------------------------------------------------------------------------
//
//  channel | signals                                 | transfer when
//  --------+-----------------------------------------+------------------------
//  in      | in_valid, in_stall, in_data (x, y)      | in_valid & !in_stall
//  out     | out_valid, out_stall, out_data          | out_valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// One item per cycle while out_stall is low. The pipeline has one quadrant
// stage, one stage per CORDIC micro-rotation, then magnitude, partial
// products, product sum, rounding and saturation (output register).
// Each stage holds only while its successor is full and held, so bubbles
// close up and in_stall rises only when every stage is occupied.
// Reset clears the valid bits and restores the registers to angle 0, scale 1.0.
//
module point_rotate_and_scale_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  prs_pkg::point_in_t                  in_data,

	output logic                                out_valid,
	input  logic                                out_stall,
	output prs_pkg::point_out_t                 out_data,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [prs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CB    = prs_pkg::COORD_BITS;
	localparam int N     = (CORDIC_STEPS < prs_pkg::ATAN_ENTRIES) ?
	                       CORDIC_STEPS : prs_pkg::ATAN_ENTRIES;
	// datapath: coordinate, fraction, headroom for quadrant negate and gain
	localparam int DW    = CB + prs_pkg::FRAC_BITS + 3;
	localparam int AW    = prs_pkg::ANGLE_BITS;
	localparam int GW    = prs_pkg::GAIN_BITS;
	localparam int GL    = GW / 2;
	localparam int GH    = GW - GL;
	localparam int ML    = (DW + 1) / 2;
	localparam int MHI   = DW - ML;
	localparam int PW    = DW + GW;
	localparam int QW    = PW - 32;
	localparam int TW    = QW + 2;
	localparam int RW    = TW - 22;

	localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (CB - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
	localparam logic signed [TW-1:0] HALF = TW'(64'sd1 <<< 21);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0]   angle_q;
	logic [15:0]   scale_q;
	logic [GW-1:0] gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= prs_pkg::ROTATION_ANGLE_RESET;
			scale_q <= prs_pkg::SCALE_FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prs_pkg::REG_ROTATION_ANGLE: angle_q <= cfg_data[15:0];
				prs_pkg::REG_SCALE_FACTOR:   scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// gain = 1/K * scale, Q0.30 x Q8.8; registered, so it follows scale_q in the next cycle
	always_ff @(posedge clk) begin
		gain_q <= GW'(prs_pkg::INV_GAIN_Q30) * GW'(scale_q);
	end

	// ------------------------------------------------------------------
	// Stage advance chain, output end first
	// ------------------------------------------------------------------
	logic              v_so, v_sf, v_ss, v_sm, v_sa;
	logic              adv_so, adv_sf, adv_ss, adv_sm, adv_sa;
	logic [N:0]        cv_s;
	logic [N:0]        adv_c;

	assign adv_so = !v_so || !out_stall;
	assign adv_sf = !v_sf || adv_so;
	assign adv_ss = !v_ss || adv_sf;
	assign adv_sm = !v_sm || adv_ss;
	assign adv_sa = !v_sa || adv_sm;

	assign adv_c[N] = !cv_s[N] || adv_sa;
	for (genvar k = 0; k < N; k++) begin : g_adv
		assign adv_c[k] = !cv_s[k] || adv_c[k+1];
	end

	assign in_stall = !adv_c[0];

	// ------------------------------------------------------------------
	// Entry stage: quadrant rotation and residual angle
	// ------------------------------------------------------------------
	logic [15:0]            ang_sum;
	prs_pkg::quad_t         quad;
	logic signed [15:0]     res;
	logic signed [DW-1:0]   x0, y0, xq, yq;

	assign ang_sum = angle_q + 16'h2000;
	assign quad    = prs_pkg::quad_t'(ang_sum[15:14]);
	assign res     = $signed(angle_q - {ang_sum[15:14], 14'd0});
	assign x0      = {{(DW-CB){in_data.x_in[CB-1]}}, in_data.x_in};
	assign y0      = {{(DW-CB){in_data.y_in[CB-1]}}, in_data.y_in};

	always_comb begin
		case (quad)
			prs_pkg::QUAD_90:  begin xq = -y0; yq = x0;  end
			prs_pkg::QUAD_180: begin xq = -x0; yq = -y0; end
			prs_pkg::QUAD_270: begin xq = y0;  yq = -x0; end
			default:           begin xq = x0;  yq = y0;  end
		endcase
	end

	logic signed [DW-1:0] cx_s [0:N];
	logic signed [DW-1:0] cy_s [0:N];
	logic signed [AW-1:0] cz_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (adv_c[0]) begin
			cv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_c[0]) begin
			cx_s[0] <= xq <<< prs_pkg::FRAC_BITS;
			cy_s[0] <= yq <<< prs_pkg::FRAC_BITS;
			cz_s[0] <= {res, 16'd0};
		end
	end

	// ------------------------------------------------------------------
	// CORDIC micro-rotations, one per stage
	// ------------------------------------------------------------------
	for (genvar k = 0; k < N; k++) begin : g_cordic
		logic signed [DW-1:0] xs, ys;
		logic signed [AW-1:0] at;

		assign xs = cx_s[k] >>> k;
		assign ys = cy_s[k] >>> k;
		assign at = prs_pkg::atan_turns(5'(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[k+1] <= 1'b0;
			end else if (adv_c[k+1]) begin
				cv_s[k+1] <= cv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv_c[k+1]) begin
				if (!cz_s[k][AW-1]) begin
					cx_s[k+1] <= cx_s[k] - ys;
					cy_s[k+1] <= cy_s[k] + xs;
					cz_s[k+1] <= cz_s[k] - at;
				end else begin
					cx_s[k+1] <= cx_s[k] + ys;
					cy_s[k+1] <= cy_s[k] - xs;
					cz_s[k+1] <= cz_s[k] + at;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Magnitude and sign of each coordinate
	// ------------------------------------------------------------------
	logic [DW-1:0] mag_x_sa, mag_y_sa;
	logic          neg_x_sa, neg_y_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else if (adv_sa) begin
			v_sa <= cv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sa) begin
			neg_x_sa <= cx_s[N][DW-1];
			neg_y_sa <= cy_s[N][DW-1];
			mag_x_sa <= cx_s[N][DW-1] ? DW'(-cx_s[N]) : DW'(cx_s[N]);
			mag_y_sa <= cy_s[N][DW-1] ? DW'(-cy_s[N]) : DW'(cy_s[N]);
		end
	end

	// ------------------------------------------------------------------
	// Partial products of magnitude and gain
	// ------------------------------------------------------------------
	logic [ML+GL-1:0]  xll_sm, yll_sm;
	logic [ML+GH-1:0]  xlh_sm, ylh_sm;
	logic [MHI+GL-1:0] xhl_sm, yhl_sm;
	logic [MHI+GH-1:0] xhh_sm, yhh_sm;
	logic              neg_x_sm, neg_y_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
		end else if (adv_sm) begin
			v_sm <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sm) begin
			neg_x_sm <= neg_x_sa;
			neg_y_sm <= neg_y_sa;
			xll_sm   <= mag_x_sa[ML-1:0]  * gain_q[GL-1:0];
			xlh_sm   <= mag_x_sa[ML-1:0]  * gain_q[GW-1:GL];
			xhl_sm   <= mag_x_sa[DW-1:ML] * gain_q[GL-1:0];
			xhh_sm   <= mag_x_sa[DW-1:ML] * gain_q[GW-1:GL];
			yll_sm   <= mag_y_sa[ML-1:0]  * gain_q[GL-1:0];
			ylh_sm   <= mag_y_sa[ML-1:0]  * gain_q[GW-1:GL];
			yhl_sm   <= mag_y_sa[DW-1:ML] * gain_q[GL-1:0];
			yhh_sm   <= mag_y_sa[DW-1:ML] * gain_q[GW-1:GL];
		end
	end

	// ------------------------------------------------------------------
	// Sum of partial products, drop 32 fraction bits (Q22 result)
	// ------------------------------------------------------------------
	logic [PW-1:0] px, py;
	logic [QW-1:0] qx_ss, qy_ss;
	logic          neg_x_ss, neg_y_ss;

	assign px = PW'(xll_sm) + (PW'(xlh_sm) << GL) + (PW'(xhl_sm) << ML)
	          + (PW'(xhh_sm) << (ML + GL));
	assign py = PW'(yll_sm) + (PW'(ylh_sm) << GL) + (PW'(yhl_sm) << ML)
	          + (PW'(yhh_sm) << (ML + GL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ss <= 1'b0;
		end else if (adv_ss) begin
			v_ss <= v_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_ss) begin
			neg_x_ss <= neg_x_sm;
			neg_y_ss <= neg_y_sm;
			qx_ss    <= px[PW-1:32];
			qy_ss    <= py[PW-1:32];
		end
	end

	// ------------------------------------------------------------------
	// Restore sign and add one half
	// ------------------------------------------------------------------
	logic signed [TW-1:0] sqx, sqy;
	logic signed [TW-1:0] tx_sf, ty_sf;

	assign sqx = neg_x_ss ? -$signed({2'b00, qx_ss}) : $signed({2'b00, qx_ss});
	assign sqy = neg_y_ss ? -$signed({2'b00, qy_ss}) : $signed({2'b00, qy_ss});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (adv_sf) begin
			v_sf <= v_ss;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sf) begin
			tx_sf <= sqx + HALF;
			ty_sf <= sqy + HALF;
		end
	end

	// ------------------------------------------------------------------
	// Truncate toward zero and saturate (output register)
	// ------------------------------------------------------------------
	logic signed [TW-1:0] ntx, nty;
	logic signed [RW-1:0] rx, ry, ox, oy;
	logic                 satx, saty;

	assign ntx = -tx_sf;
	assign nty = -ty_sf;
	assign rx  = tx_sf[TW-1] ? -$signed(RW'(ntx >>> 22)) : RW'(tx_sf >>> 22);
	assign ry  = ty_sf[TW-1] ? -$signed(RW'(nty >>> 22)) : RW'(ty_sf >>> 22);

	always_comb begin
		satx = 1'b1;
		saty = 1'b1;
		if (rx > MAXV) begin
			ox = MAXV;
		end else if (rx < MINV) begin
			ox = MINV;
		end else begin
			ox   = rx;
			satx = 1'b0;
		end
		if (ry > MAXV) begin
			oy = MAXV;
		end else if (ry < MINV) begin
			oy = MINV;
		end else begin
			oy   = ry;
			saty = 1'b0;
		end
	end

	logic signed [CB-1:0] x_so, y_so;
	logic                 clip_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (adv_so) begin
			v_so <= v_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_so) begin
			x_so    <= ox[CB-1:0];
			y_so    <= oy[CB-1:0];
			clip_so <= satx || saty;
		end
	end

	assign out_valid        = v_so;
	assign out_data.x_out   = x_so;
	assign out_data.y_out   = y_so;
	assign out_data.clipped = clip_so;

endmodule

// ===== tb/point_rotate_and_scale_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_rotate_and_scale_unit_tb
// Self-checking bench for the point rotate and scale unit. A directed list of
// points and register settings covers the reset values, quadrant boundaries,
// zero scale and saturation. Random phases follow, each with a fresh angle and
// scale. An in-bench CORDIC predictor supplies the expected x, y and clip flag
// of each accepted point without a listed result. The sender works in bursts,
// the receiver stalls on patterns of its own, including one long hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module point_rotate_and_scale_unit_tb;

	localparam int STEPS           = 16;
	localparam int PIPE_DEPTH      = STEPS + 6;
	localparam int HOLD_OFF_CYCLES = 4 * PIPE_DEPTH;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int PRESSURE_PHASE  = 2;

	// Register indexes that decode to nothing
	localparam logic [prs_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST =
		prs_pkg::CFG_INDEX_BITS'(2);
	localparam logic [prs_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_LAST  = '1;

	localparam longint COORD_MAX = (64'sd1 <<< (prs_pkg::COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	typedef struct packed {
		logic [15:0]         angle;
		logic [15:0]         scale;
		prs_pkg::point_in_t  pt;
		logic                typed;
		prs_pkg::point_out_t result;
	} directed_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	prs_pkg::point_in_t                 in_data;
	logic                               out_valid;
	logic                               out_stall;
	prs_pkg::point_out_t                out_data;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [prs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [prs_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	// Shadow copy of the unit's registers
	logic [15:0]         angle_reg;
	logic [15:0]         scale_reg;
	longint              atan_step [prs_pkg::ATAN_ENTRIES];
	prs_pkg::point_out_t pending_points [$];
	directed_row_t       directed_rows [$];
	prs_pkg::point_out_t want_point;
	int                  mismatch_count;
	bit                  hold_off_request;

	point_rotate_and_scale_unit #(
		.CORDIC_STEPS (STEPS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	initial begin
		#5000000;
		$display("point_rotate_and_scale_unit regression: fail");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Gain removal and scale, round half up, truncate toward zero, saturate
	function automatic logic signed [prs_pkg::COORD_BITS-1:0] round_saturate(input longint v,
			input logic [63:0] gain, inout logic clip);
		logic [127:0] prod;
		longint       q;
		prod = 128'(v < 0 ? -v : v) * 128'(gain);
		q = longint'(prod[95:32]);
		if (v < 0)
			q = -q;
		q = q + 64'sd2097152;
		if (q >= 0)
			q = q >>> 22;
		else
			q = -((-q) >>> 22);
		if (q > COORD_MAX) begin
			clip = 1'b1;
			q = COORD_MAX;
		end else if (q < COORD_MIN) begin
			clip = 1'b1;
			q = COORD_MIN;
		end
		return q[prs_pkg::COORD_BITS-1:0];
	endfunction

	// Expected output for one point under the current registers
	function automatic prs_pkg::point_out_t rotate_scale_point(input prs_pkg::point_in_t p);
		longint              x;
		longint              y;
		longint              z;
		longint              nx;
		longint              ny;
		longint              residual;
		logic [16:0]         biased;
		prs_pkg::quad_t      quad;
		logic [63:0]         gain;
		logic                clip;
		prs_pkg::point_out_t r;
		biased = {1'b0, angle_reg} + 17'h2000;
		quad = prs_pkg::quad_t'(biased[15:14]);
		residual = longint'(angle_reg) - 16384 * longint'(quad);
		if (residual >= 32768)
			residual = residual - 65536;
		// exact quarter turns first
		case (quad)
			prs_pkg::QUAD_90: begin
				x = -longint'(p.y_in);
				y = longint'(p.x_in);
			end
			prs_pkg::QUAD_180: begin
				x = -longint'(p.x_in);
				y = -longint'(p.y_in);
			end
			prs_pkg::QUAD_270: begin
				x = longint'(p.y_in);
				y = -longint'(p.x_in);
			end
			default: begin
				x = longint'(p.x_in);
				y = longint'(p.y_in);
			end
		endcase
		x = x * 65536;
		y = y * 65536;
		z = residual * 65536;
		// residual angle by micro-rotations, shifts floor toward minus infinity
		for (int i = 0; i < STEPS && i < prs_pkg::ATAN_ENTRIES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_step[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_step[i];
			end
			x = nx;
			y = ny;
		end
		gain = 64'(prs_pkg::INV_GAIN_Q30) * 64'(scale_reg);
		clip = 1'b0;
		r.x_out = round_saturate(x, gain, clip);
		r.y_out = round_saturate(y, gain, clip);
		r.clipped = clip;
		return r;
	endfunction

	function automatic logic signed [prs_pkg::COORD_BITS-1:0] pick_coord();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(5))
					0: return COORD_MIN[prs_pkg::COORD_BITS-1:0];
					1: return COORD_MAX[prs_pkg::COORD_BITS-1:0];
					2: return prs_pkg::COORD_BITS'(-32767);
					3: return prs_pkg::COORD_BITS'(-1);
					4: return prs_pkg::COORD_BITS'(1);
					default: return '0;
				endcase
			end
			1, 2: return prs_pkg::COORD_BITS'($signed($urandom_range(600)) - 300);
			default: return prs_pkg::COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(7))
			0: return 16'($urandom_range(3) << 14);
			// around the points where the quadrant choice flips
			1: return 16'(($urandom_range(3) << 14) + 32'h2000 + $urandom_range(2) - 1);
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd1;
			3: return 16'd256;
			4: return 16'($urandom);
			default: return 16'($urandom_range(64, 640));
		endcase
	endfunction

	function automatic void add_row(input logic [15:0] angle, input logic [15:0] scale,
			input int x, input int y, input bit typed,
			input int ex = 0, input int ey = 0, input bit ec = 1'b0);
		directed_row_t row;
		row.angle = angle;
		row.scale = scale;
		row.pt.x_in = prs_pkg::COORD_BITS'(x);
		row.pt.y_in = prs_pkg::COORD_BITS'(y);
		row.typed = typed;
		row.result.x_out = prs_pkg::COORD_BITS'(ex);
		row.result.y_out = prs_pkg::COORD_BITS'(ey);
		row.result.clipped = ec;
		directed_rows.push_back(row);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_point(input prs_pkg::point_in_t p, input bit typed,
			input prs_pkg::point_out_t result);
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_points.push_back(typed ? result : rotate_scale_point(p));
		@(negedge clk);
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Wait until every expected item has come out
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [prs_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == prs_pkg::REG_ROTATION_ANGLE)
			angle_reg = val;
		else if (idx == prs_pkg::REG_SCALE_FACTOR)
			scale_reg = val;
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [15:0] angle, input logic [15:0] scale);
		bit angle_first;
		angle_first = $urandom_range(1);
		if (angle_first)
			write_reg(prs_pkg::REG_ROTATION_ANGLE, angle);
		write_reg(prs_pkg::REG_SCALE_FACTOR, scale);
		if (!angle_first)
			write_reg(prs_pkg::REG_ROTATION_ANGLE, angle);
		// a stray write to an unmapped index now and then
		if ($urandom_range(2) == 0)
			write_reg(prs_pkg::CFG_INDEX_BITS'($urandom_range(2, 255)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Output check against the oldest expectation
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected item x=%0d y=%0d clipped=%0b",
					out_data.x_out, out_data.y_out, out_data.clipped));
			end else begin
				want_point = pending_points.pop_front();
				if (out_data.x_out !== want_point.x_out)
					report_mismatch($sformatf("x_out got %0d want %0d",
						out_data.x_out, want_point.x_out));
				if (out_data.y_out !== want_point.y_out)
					report_mismatch($sformatf("y_out got %0d want %0d",
						out_data.y_out, want_point.y_out));
				if (out_data.clipped !== want_point.clipped)
					report_mismatch($sformatf("clipped got %0b want %0b",
						out_data.clipped, want_point.clipped));
			end
		end
	end

	// Receiver: picks a new stall mode after each random span
	initial begin : receiver
		int         mode;
		int         span;
		logic [7:0] pattern;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(3);
			span = $urandom_range(32, 96);
			pattern = 8'($urandom);
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				if (hold_off_request) begin
					// long hold so the pipeline fills and backs up into the input
					hold_off_request = 1'b0;
					out_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					out_stall <= 1'b0;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(2) == 0);
						2: out_stall <= pattern[c % 8];
						default: out_stall <= ($urandom_range(2) != 0);
					endcase
				end
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		prs_pkg::point_in_t pt;
		int                 sent;
		int                 burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		hold_off_request = 1'b0;
		angle_reg = prs_pkg::ROTATION_ANGLE_RESET;
		scale_reg = prs_pkg::SCALE_FACTOR_RESET;
		for (int i = 0; i < prs_pkg::ATAN_ENTRIES; i++)
			atan_step[i] = longint'($atan(1.0 / (2.0 ** i)) / (2.0 * 3.14159265358979323846)
				* 4294967296.0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unmapped indexes must leave the reset values alone
		write_reg(REG_UNUSED_FIRST, 16'hFFFF);
		write_reg(REG_UNUSED_LAST, 16'h0000);
		cfg_valid <= 1'b0;

		// directed points: reset values, quadrants, boundaries, zero scale, saturation
		add_row(prs_pkg::ROTATION_ANGLE_RESET, prs_pkg::SCALE_FACTOR_RESET, 0, 0, 1'b1,
			0, 0, 1'b0);
		add_row(prs_pkg::ROTATION_ANGLE_RESET, prs_pkg::SCALE_FACTOR_RESET, 32767, -32768,
			1'b0);
		add_row(prs_pkg::ROTATION_ANGLE_RESET, prs_pkg::SCALE_FACTOR_RESET, -32768, 32767,
			1'b0);
		add_row(prs_pkg::ROTATION_ANGLE_RESET, prs_pkg::SCALE_FACTOR_RESET, 1, -1, 1'b0);
		add_row(16'h4000, 16'd256, 1000, 0, 1'b0);
		add_row(16'h8000, 16'd256, -32768, -32768, 1'b0);
		add_row(16'hC000, 16'd256, 123, -456, 1'b0);
		add_row(16'h2000, 16'd256, 20000, 20000, 1'b0);
		add_row(16'h1FFF, 16'd256, 20000, -20000, 1'b0);
		add_row(16'hFFFF, 16'd256, -12345, 30000, 1'b0);
		add_row(16'hE000, 16'd256, 32767, 32767, 1'b0);
		add_row(16'h1234, 16'd0, 32767, 32767, 1'b1, 0, 0, 1'b0);
		add_row(16'h1234, 16'd0, -32768, -32768, 1'b1, 0, 0, 1'b0);
		add_row(16'h0000, 16'hFFFF, 32767, 32767, 1'b1, 32767, 32767, 1'b1);
		add_row(16'h0000, 16'hFFFF, -32768, -32768, 1'b1, -32768, -32768, 1'b1);
		add_row(16'h0000, 16'hFFFF, 0, 0, 1'b1, 0, 0, 1'b0);
		add_row(16'h0000, 16'hFFFF, 200, -1, 1'b0);
		add_row(16'h8000, 16'hFFFF, 32767, 32767, 1'b1, -32768, -32768, 1'b1);
		add_row(16'h0800, 16'd1, 32767, -32768, 1'b0);
		add_row(16'h6000, 16'd512, -20000, 15000, 1'b0);
		add_row(16'h3FFF, 16'd256, 32767, 0, 1'b0);
		add_row(16'h3FFF, 16'd256, -1, -32768, 1'b0);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].angle != angle_reg || directed_rows[k].scale != scale_reg) begin
				drain_pipe();
				program_regs(directed_rows[k].angle, directed_rows[k].scale);
			end
			send_point(directed_rows[k].pt, directed_rows[k].typed, directed_rows[k].result);
			if (k % 3 == 2)
				idle(1);
		end

		// random phases, each under its own angle and scale
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_pipe();
			program_regs(pick_angle(), pick_scale());
			if (ph == PRESSURE_PHASE)
				hold_off_request = 1'b1;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
					pt.x_in = pick_coord();
					pt.y_in = pick_coord();
					send_point(pt, 1'b0, '0);
					sent++;
				end
				// pressure phase offers items back to back
				if (ph != PRESSURE_PHASE && $urandom_range(3) != 0)
					idle($urandom_range(1, 8));
			end
		end

		drain_pipe();
		repeat (PIPE_DEPTH) @(negedge clk);
		if (mismatch_count == 0)
			$display("point_rotate_and_scale_unit regression: pass");
		else
			$display("point_rotate_and_scale_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/prs_pkg.sv
rtl/point_rotate_and_scale_unit.sv
tb/point_rotate_and_scale_unit_tb.sv
